### rtl/core/scl_pkg.sv
// Shared types, codes and keyword tables for the serial command line decoder.
`default_nettype none

package scl_pkg;

    localparam int unsigned LINE_CAPACITY_DEFAULT = 128;

    localparam int unsigned ACC_W = 17;
    localparam logic [ACC_W-1:0] ACC_SAT = 17'd65536;
    localparam logic [ACC_W-1:0] VALUE_MAX = 17'd65535;
    localparam logic [ACC_W-1:0] MARKER_MAX = 17'd255;

    localparam int unsigned KW_COUNT = 5;
    localparam logic [2:0] KW_CLR = 3'd0;
    localparam logic [2:0] KW_LOADED = 3'd1;
    localparam logic [2:0] KW_START = 3'd2;
    localparam logic [2:0] KW_STOP = 3'd3;
    localparam logic [2:0] KW_DATA = 3'd4;

    localparam logic [2:0] FIELD_COUNT = 3'd4;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [2:0] STOP_LEN = 3'd4;

    typedef enum logic [3:0] {
        EV_CLR         = 4'd0,
        EV_LOADED      = 4'd1,
        EV_START       = 4'd2,
        EV_STOP        = 4'd3,
        EV_DATA        = 4'd4,
        EV_UNKNOWN     = 4'd5,
        EV_BAD_DATA    = 4'd6,
        EV_RANGE       = 4'd7,
        EV_TOO_LONG    = 4'd8,
        EV_RX_OVERFLOW = 4'd9
    } t_event;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_cmd;

    typedef struct packed {
        t_event      event_res;
        logic        fast_stop;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [15:0] value_c;
        logic [15:0] value_d;
        logic [7:0]  marker;
    } t_evt;

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        logic [3:0] n;
        case (k)
            KW_CLR:    n = 4'd3;
            KW_LOADED: n = 4'd9;
            KW_START:  n = 4'd5;
            KW_STOP:   n = 4'd4;
            KW_DATA:   n = 4'd5;
            default:   n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] p);
        logic [71:0] s;
        logic [3:0]  n;
        int          sh;
        n = kw_len(k);
        case (k)
            KW_CLR:    s = 72'("CLR");
            KW_LOADED: s = 72'({"LOAD_", "DONE"});
            KW_START:  s = 72'("START");
            KW_STOP:   s = 72'("STOP");
            KW_DATA:   s = 72'("DATA,");
            default:   s = '0;
        endcase
        sh = 8 * (int'(n) - 1 - int'(p));
        if (p < n) begin
            return s[sh +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] stop_char(input logic [1:0] p);
        logic [7:0] c;
        case (p)
            2'd0:    c = 8'h53;
            2'd1:    c = 8'h54;
            2'd2:    c = 8'h4F;
            default: c = 8'h50;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/scl_cmd_if.sv
// Stream interface that carries received byte beats into the decoder.
`default_nettype none

interface scl_cmd_if;
    import scl_pkg::*;

    logic valid;
    logic ready;
    t_cmd payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/scl_evt_if.sv
// Stream interface that carries decoded line events out of the decoder.
`default_nettype none

interface scl_evt_if;
    import scl_pkg::*;

    logic valid;
    logic ready;
    t_evt payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/scl_stop_matcher.sv
// Fast matcher that flags a line consisting of exactly STOP.
`default_nettype none

module scl_stop_matcher (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_step,
    input  wire scl_pkg::t_cmd i_cmd,
    output logic              o_fast
);
    import scl_pkg::*;

    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic       r_dead;
    logic       n_dead;

    assign o_fast = !r_dead && (r_pos == STOP_LEN);

    always_comb begin
        n_pos = r_pos;
        n_dead = r_dead;
        if (i_step && !i_cmd.action) begin
            if (i_cmd.rx_byte == CH_LF) begin
                n_pos = '0;
                n_dead = 1'b0;
            end else if (i_cmd.rx_byte != CH_CR && !r_dead) begin
                if (r_pos < STOP_LEN && i_cmd.rx_byte == stop_char(r_pos[1:0])) begin
                    n_pos = r_pos + 3'd1;
                end else begin
                    n_dead = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_dead <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_dead <= n_dead;
        end
    end

endmodule

`default_nettype wire

### rtl/core/scl_line_decoder.sv
// Per-byte line decoder: keyword matching, data field parsing and event selection.
`default_nettype none

module scl_line_decoder #(
    parameter int unsigned LINE_CAPACITY = scl_pkg::LINE_CAPACITY_DEFAULT
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire scl_pkg::t_cmd i_cmd,
    input  wire logic          i_fast,
    output logic               o_res_valid,
    output scl_pkg::t_evt      o_res
);
    import scl_pkg::*;

    localparam int unsigned LW = $clog2(LINE_CAPACITY);
    localparam logic [LW-1:0] LEN_LIMIT = LW'(LINE_CAPACITY - 1);

    logic [LW-1:0]      r_len;
    logic [LW-1:0]      n_len;
    logic               r_too_long;
    logic               n_too_long;
    logic [KW_COUNT-1:0] r_alive;
    logic [KW_COUNT-1:0] n_alive;
    logic [2:0]         r_idx;
    logic [2:0]         n_idx;
    logic [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   n_acc;
    logic               r_digit;
    logic               n_digit;
    logic               r_bad;
    logic               n_bad;
    logic               r_big;
    logic               n_big;
    logic [15:0]        r_fv [4];

    logic               fv_we;
    logic [1:0]         fv_sel;
    logic [7:0]         ch;
    logic [19:0]        prod;
    t_event             ev;

    assign ch = i_cmd.rx_byte;
    assign prod = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + {16'h0000, 4'(ch - CH_ZERO)};

    always_comb begin
        ev = EV_UNKNOWN;
        if (r_too_long) begin
            ev = EV_TOO_LONG;
        end else if (r_alive[KW_CLR] && r_len == LW'(kw_len(KW_CLR))) begin
            ev = EV_CLR;
        end else if (r_alive[KW_LOADED] && r_len == LW'(kw_len(KW_LOADED))) begin
            ev = EV_LOADED;
        end else if (r_alive[KW_START] && r_len == LW'(kw_len(KW_START))) begin
            ev = EV_START;
        end else if (r_alive[KW_STOP] && r_len == LW'(kw_len(KW_STOP))) begin
            ev = EV_STOP;
        end else if (r_alive[KW_DATA] && r_len >= LW'(kw_len(KW_DATA))) begin
            if (r_bad || r_idx != FIELD_COUNT || !r_digit) begin
                ev = EV_BAD_DATA;
            end else if (r_big || r_acc > MARKER_MAX) begin
                ev = EV_RANGE;
            end else begin
                ev = EV_DATA;
            end
        end
    end

    always_comb begin
        n_len = r_len;
        n_too_long = r_too_long;
        n_alive = r_alive;
        n_idx = r_idx;
        n_acc = r_acc;
        n_digit = r_digit;
        n_bad = r_bad;
        n_big = r_big;
        fv_we = 1'b0;
        fv_sel = r_idx[1:0];
        o_res_valid = 1'b0;
        o_res = '0;

        if (i_step) begin
            if (i_cmd.action || ch == CH_LF) begin
                if (i_cmd.action) begin
                    o_res_valid = 1'b1;
                    o_res.event_res = EV_RX_OVERFLOW;
                end else if (r_too_long || r_len != '0) begin
                    o_res_valid = 1'b1;
                    o_res.event_res = ev;
                    o_res.fast_stop = i_fast;
                    if (ev == EV_DATA) begin
                        o_res.value_a = r_fv[0];
                        o_res.value_b = r_fv[1];
                        o_res.value_c = r_fv[2];
                        o_res.value_d = r_fv[3];
                        o_res.marker = r_acc[7:0];
                    end
                end
                n_len = '0;
                n_too_long = 1'b0;
                n_alive = '1;
                n_idx = '0;
                n_acc = '0;
                n_digit = 1'b0;
                n_bad = 1'b0;
                n_big = 1'b0;
            end else if (ch != CH_CR) begin
                if (r_len < LEN_LIMIT) begin
                    for (int k = 0; k < KW_COUNT; k++) begin
                        if (r_alive[k]) begin
                            if (r_len < LW'(kw_len(3'(k)))) begin
                                if (kw_char(3'(k), r_len[3:0]) != ch) begin
                                    n_alive[k] = 1'b0;
                                end
                            end else if (3'(k) != KW_DATA) begin
                                n_alive[k] = 1'b0;
                            end
                        end
                    end
                    if (r_len >= LW'(kw_len(KW_DATA)) && r_alive[KW_DATA] && !r_bad) begin
                        if (ch >= CH_ZERO && ch <= CH_NINE) begin
                            n_acc = (prod > 20'(ACC_SAT)) ? ACC_SAT : prod[ACC_W-1:0];
                            n_digit = 1'b1;
                        end else if (ch == CH_COMMA) begin
                            if (!r_digit || r_idx >= FIELD_COUNT) begin
                                n_bad = 1'b1;
                            end else begin
                                if (r_acc > VALUE_MAX) begin
                                    n_big = 1'b1;
                                end
                                fv_we = 1'b1;
                                n_idx = r_idx + 3'd1;
                                n_acc = '0;
                                n_digit = 1'b0;
                            end
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    n_len = r_len + LW'(1);
                end else begin
                    n_too_long = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_too_long <= 1'b0;
            r_alive <= '1;
            r_idx <= '0;
            r_acc <= '0;
            r_digit <= 1'b0;
            r_bad <= 1'b0;
            r_big <= 1'b0;
        end else begin
            r_len <= n_len;
            r_too_long <= n_too_long;
            r_alive <= n_alive;
            r_idx <= n_idx;
            r_acc <= n_acc;
            r_digit <= n_digit;
            r_bad <= n_bad;
            r_big <= n_big;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fv_we) begin
            r_fv[fv_sel] <= r_acc[15:0];
        end
    end

endmodule

`default_nettype wire

### rtl/core/serial_command_line_decoder.sv
// A byte beat in the input register is decoded from there; any event it yields goes to
// the output register. Throughput: one beat per cycle; the input register is freed whenever
// the output register is empty or being read, so only an unread waiting event stalls input.
// Reset (synchronous, active low) clears the line state, the STOP matcher and both valid
// flags; the four stored data values are not reset and are only read once rewritten.
`default_nettype none

module serial_command_line_decoder #(
    parameter int unsigned LINE_CAPACITY = scl_pkg::LINE_CAPACITY_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    scl_cmd_if.sink   i_cmd,
    scl_evt_if.source o_evt
);
    import scl_pkg::*;

    logic r_in_valid;
    t_cmd r_in;
    logic r_out_valid;
    t_evt r_out;
    logic proc;
    logic fast;
    logic res_valid;
    t_evt res;

    assign proc = r_in_valid && (!r_out_valid || o_evt.ready);
    assign i_cmd.ready = !r_in_valid || proc;
    assign o_evt.valid = r_out_valid;
    assign o_evt.payload = r_out;

    scl_stop_matcher u_stop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (proc),
        .i_cmd   (r_in),
        .o_fast  (fast)
    );

    scl_line_decoder #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_line (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (proc),
        .i_cmd       (r_in),
        .i_fast      (fast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
            if (proc && res_valid) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in <= i_cmd.payload;
        end
        if (proc && res_valid) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the serial command line decoder, with a line predictor.
`default_nettype none

module tb;
    import scl_pkg::*;

    localparam int unsigned LINE_CAP = scl_pkg::LINE_CAPACITY_DEFAULT;
    localparam int unsigned RANDOM_BEATS = 1300;
    localparam int unsigned TAIL_BEATS = 150;
    localparam int unsigned LIMIT_CYCLES = 400000;

    typedef struct {
        t_cmd beat;
        bit   hold;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    scl_cmd_if cmd_if ();
    scl_evt_if evt_if ();

    serial_command_line_decoder #(
        .LINE_CAPACITY(LINE_CAP)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_evt  (evt_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Line predictor state.
    logic [$clog2(LINE_CAP)-1:0] line_len;
    logic                        line_overrun;
    logic [4:0]                  kw_live;
    logic [2:0]                  field_idx;
    logic [16:0]                 num_acc;
    logic                        num_has_digit;
    logic                        data_broken;
    logic                        data_overflowed;
    logic [15:0]                 field_store [4];
    logic [2:0]                  stop_pos;
    logic                        stop_dead;
    string                       stop_word = "STOP";

    t_evt        expected_events [$];
    t_pending    pending_beats [$];
    bit          hold_next = 1'b0;
    int unsigned beats_queued = 0;
    int unsigned beats_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    bit          send_idle_on = 1'b1;
    bit          recv_idle_on = 1'b1;

    function automatic string keyword_text(int k);
        string head;
        head = "LOAD";
        case (k)
            KW_CLR:    return "CLR";
            KW_LOADED: return {head, "_DONE"};
            KW_START:  return "START";
            KW_STOP:   return "STOP";
            KW_DATA:   return "DATA,";
            default:   return "";
        endcase
    endfunction

    task automatic clear_line();
        line_len = '0;
        line_overrun = 1'b0;
        kw_live = '1;
        field_idx = '0;
        num_acc = '0;
        num_has_digit = 1'b0;
        data_broken = 1'b0;
        data_overflowed = 1'b0;
    endtask

    task automatic data_char(logic [7:0] ch);
        int unsigned grown;
        if (!data_broken) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                grown = num_acc * 10 + (ch - CH_ZERO);
                num_acc = (grown > ACC_SAT) ? ACC_SAT : 17'(grown);
                num_has_digit = 1'b1;
            end else if (ch == CH_COMMA) begin
                if (!num_has_digit || field_idx >= FIELD_COUNT) begin
                    data_broken = 1'b1;
                end else begin
                    if (num_acc > VALUE_MAX) begin
                        data_overflowed = 1'b1;
                    end
                    field_store[field_idx[1:0]] = num_acc[15:0];
                    field_idx = field_idx + 3'd1;
                    num_acc = '0;
                    num_has_digit = 1'b0;
                end
            end else begin
                data_broken = 1'b1;
            end
        end
    endtask

    task automatic store_char(logic [7:0] ch);
        string kw;
        int    p;
        p = line_len;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (kw_live[k]) begin
                kw = keyword_text(k);
                if (p < kw.len()) begin
                    if (kw[p] != ch) begin
                        kw_live[k] = 1'b0;
                    end
                end else if (k != KW_DATA) begin
                    kw_live[k] = 1'b0;
                end
            end
        end
        kw = keyword_text(KW_DATA);
        if (p >= kw.len() && kw_live[KW_DATA]) begin
            data_char(ch);
        end
        line_len = line_len + 1'b1;
    endtask

    function automatic t_evt line_event(logic fast);
        t_evt  r;
        string kw;
        bit    found;
        r = '0;
        r.fast_stop = fast;
        found = 1'b0;
        if (line_overrun) begin
            r.event_res = EV_TOO_LONG;
        end else begin
            r.event_res = EV_UNKNOWN;
            for (int k = 0; k < KW_DATA; k++) begin
                kw = keyword_text(k);
                if (!found && kw_live[k] && line_len == kw.len()) begin
                    r.event_res = t_event'(k);
                    found = 1'b1;
                end
            end
            kw = keyword_text(KW_DATA);
            if (!found && kw_live[KW_DATA] && line_len >= kw.len()) begin
                if (data_broken || field_idx != FIELD_COUNT || !num_has_digit) begin
                    r.event_res = EV_BAD_DATA;
                end else if (data_overflowed || num_acc > MARKER_MAX) begin
                    r.event_res = EV_RANGE;
                end else begin
                    r.event_res = EV_DATA;
                    r.value_a = field_store[0];
                    r.value_b = field_store[1];
                    r.value_c = field_store[2];
                    r.value_d = field_store[3];
                    r.marker = num_acc[7:0];
                end
            end
        end
        return r;
    endfunction

    task automatic decode_beat(t_cmd beat);
        t_evt ev;
        logic fast;
        ev = '0;
        if (beat.action) begin
            clear_line();
            ev.event_res = EV_RX_OVERFLOW;
            expected_events.push_back(ev);
        end else if (beat.rx_byte == CH_CR) begin
            // Carriage returns are dropped by both matchers.
        end else if (beat.rx_byte == CH_LF) begin
            fast = !stop_dead && stop_pos == STOP_LEN;
            stop_pos = '0;
            stop_dead = 1'b0;
            if (line_overrun || line_len != 0) begin
                expected_events.push_back(line_event(fast));
            end
            clear_line();
        end else begin
            if (!stop_dead) begin
                if (stop_pos < STOP_LEN && beat.rx_byte == stop_word[stop_pos]) begin
                    stop_pos = stop_pos + 3'd1;
                end else begin
                    stop_dead = 1'b1;
                end
            end
            if (line_len < LINE_CAP - 1) begin
                store_char(beat.rx_byte);
            end else begin
                line_overrun = 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                      results_seen, name, got, want));
        end
    endtask

    task automatic check_event(t_evt got);
        t_evt want;
        if (expected_events.size() == 0) begin
            report_mismatch($sformatf("result %0d with event %0d arrived unexpectedly",
                                      results_seen, got.event_res));
        end else begin
            want = expected_events.pop_front();
            check_field("event_res", got.event_res, want.event_res);
            check_field("fast_stop", got.fast_stop, want.fast_stop);
            check_field("value_a", got.value_a, want.value_a);
            check_field("value_b", got.value_b, want.value_b);
            check_field("value_c", got.value_c, want.value_c);
            check_field("value_d", got.value_d, want.value_d);
            check_field("marker", got.marker, want.marker);
        end
        results_seen++;
    endtask

    function automatic bit in_tail();
        return pending_beats.size() < TAIL_BEATS;
    endfunction

    // Stimulus construction.
    task automatic push_beat(bit act, logic [7:0] b);
        t_pending item;
        item.beat.action = act;
        item.beat.rx_byte = b;
        item.hold = hold_next;
        hold_next = 1'b0;
        pending_beats.push_back(item);
        beats_queued++;
    endtask

    task automatic push_text(string s, bit sprinkle_cr);
        for (int i = 0; i < s.len(); i++) begin
            if (sprinkle_cr && $urandom_range(0, 7) == 0) begin
                push_beat(1'b0, CH_CR);
            end
            push_beat(1'b0, s[i]);
        end
    endtask

    task automatic push_line(string s);
        bit sprinkle;
        sprinkle = ($urandom_range(0, 3) == 0);
        push_text(s, sprinkle);
        if ($urandom_range(0, 3) == 0) begin
            push_beat(1'b0, CH_CR);
        end
        push_beat(1'b0, CH_LF);
    endtask

    function automatic logic [7:0] printable_char();
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic string decimal_field(bit is_marker);
        int unsigned pick;
        pick = $urandom_range(0, 29);
        case (pick)
            0:       return "0";
            1: begin
                if (is_marker) begin
                    return "255";
                end
                return "65535";
            end
            2: begin
                if (is_marker) begin
                    return "256";
                end
                return "65536";
            end
            3:       return {"000", $sformatf("%0d", $urandom_range(0, 99))};
            4:       return "123456789012";
            5:       return is_marker ? $sformatf("%0d", $urandom_range(256, 999))
                                      : $sformatf("%0d", $urandom_range(65536, 99999));
            default: return is_marker ? $sformatf("%0d", $urandom_range(0, 255))
                                      : $sformatf("%0d", $urandom_range(0, 65535));
        endcase
    endfunction

    function automatic string data_text(int fault);
        string       s;
        string       f;
        int unsigned nfields;
        int unsigned bad_pos;
        s = "DATA,";
        nfields = (fault == 0) ? 4 : (fault == 1) ? 6 : 5;
        bad_pos = $urandom_range(0, nfields - 1);
        if (fault == 7) begin
            return s;
        end
        if (fault == 8) begin
            return {s, ",,,,"};
        end
        for (int i = 0; i < nfields; i++) begin
            f = decimal_field(i == 4);
            if (i == bad_pos) begin
                case (fault)
                    2:       f = "";
                    3: begin
                        if ($urandom_range(0, 1) != 0) begin
                            f = {"+", f};
                        end else begin
                            f = {"-", f};
                        end
                    end
                    4:       f = {f, " "};
                    6:       f = {f, "x"};
                    default: ;
                endcase
            end
            s = {s, f};
            if (i < nfields - 1) begin
                s = {s, ","};
            end
        end
        if (fault == 5) begin
            s = {s, ","};
        end
        return s;
    endfunction

    task automatic push_keyword_variant();
        string       s;
        int unsigned pos;
        s = keyword_text($urandom_range(0, 3));
        pos = $urandom_range(0, s.len() - 1);
        case ($urandom_range(0, 3))
            0: s = {s, string'(printable_char())};
            1: s = s.substr(0, s.len() - 2);
            2: s[pos] = printable_char();
            default: s[0] = s[0] + 8'h20;
        endcase
        push_line(s);
    endtask

    task automatic push_long_line();
        int unsigned n;
        string       s;
        case ($urandom_range(0, 4))
            0:       n = LINE_CAP - 2;
            1:       n = LINE_CAP - 1;
            2:       n = LINE_CAP;
            3:       n = LINE_CAP + 1;
            default: n = $urandom_range(LINE_CAP + 2, LINE_CAP + 40);
        endcase
        s = "";
        if ($urandom_range(0, 1) != 0) begin
            s = "DATA,";
        end
        while (s.len() < n) begin
            s = {s, string'(printable_char())};
        end
        push_line(s);
    endtask

    task automatic push_noise();
        int unsigned n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                push_beat(1'b1, 8'($urandom_range(0, 255)));
            end else begin
                push_beat(1'b0, 8'($urandom_range(0, 255)));
            end
        end
        push_beat(1'b0, CH_LF);
    endtask

    task automatic push_stop_variant();
        case ($urandom_range(0, 5))
            0: begin
                push_text("ST", 1'b0);
                push_beat(1'b1, 8'($urandom_range(0, 255)));
                push_line("OP");
            end
            1: push_line("STOP");
            2: push_line("STOPP");
            3: push_line("sTOP");
            4: begin
                push_beat(1'b0, CH_CR);
                push_line("STOP");
            end
            default: push_line("STO");
        endcase
    endtask

    task automatic push_random_line();
        int unsigned kind;
        string       s;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            push_line(keyword_text($urandom_range(0, 3)));
        end else if (kind < 18) begin
            push_keyword_variant();
        end else if (kind < 55) begin
            push_line(data_text(-1));
        end else if (kind < 67) begin
            push_line(data_text($urandom_range(0, 8)));
        end else if (kind < 69) begin
            push_long_line();
        end else if (kind < 75) begin
            s = ($urandom_range(0, 1) != 0) ? data_text(-1) : keyword_text($urandom_range(0, 4));
            push_text(s.substr(0, $urandom_range(0, s.len() - 1)), 1'b0);
            push_beat(1'b1, 8'($urandom_range(0, 255)));
        end else if (kind < 80) begin
            push_line("");
        end else if (kind < 88) begin
            push_noise();
        end else begin
            push_stop_variant();
        end
        if ($urandom_range(0, 29) == 0) begin
            hold_next = 1'b1;
        end
    endtask

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                decode_beat(cmd_if.payload);
                beats_accepted++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (pending_beats.size() == 0) begin
                    cmd_if.valid <= 1'b0;
                end else if (pending_beats[0].hold && expected_events.size() != 0) begin
                    cmd_if.valid <= 1'b0;
                end else begin
                    cmd_if.valid <= 1'b1;
                    cmd_if.payload <= pending_beats[0].beat;
                    pending_beats.delete(0);
                    if ($urandom_range(0, 49) == 0) begin
                        send_idle_on = !send_idle_on;
                    end
                    if (send_idle_on && !in_tail() && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 17);
                    end
                end
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_if.ready <= 1'b0;
        end else begin
            if (evt_if.valid && evt_if.ready) begin
                check_event(evt_if.payload);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                evt_if.ready <= 1'b0;
            end else begin
                evt_if.ready <= 1'b1;
                if ($urandom_range(0, 39) == 0) begin
                    recv_idle_on = !recv_idle_on;
                end
                if (recv_idle_on && !in_tail() && $urandom_range(0, 5) == 0) begin
                    recv_stall = $urandom_range(1, 17);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        cmd_if.valid = 1'b0;
        cmd_if.payload = '0;
        evt_if.ready = 1'b0;
        clear_line();
        for (int i = 0; i < 4; i++) begin
            field_store[i] = '0;
        end
        stop_pos = '0;
        stop_dead = 1'b0;

        push_line("CLR");
        push_text("ST", 1'b0);
        push_beat(1'b0, CH_CR);
        push_text("OP", 1'b0);
        push_beat(1'b0, CH_LF);
        push_beat(1'b0, CH_LF);
        push_beat(1'b1, 8'hFF);
        push_beat(1'b0, 8'h00);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, CH_LF);
        push_line("DATA,");
        hold_next = 1'b1;
        push_line("START");
        while (beats_queued < RANDOM_BEATS) begin
            push_random_line();
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_accepted != beats_queued) begin
            @(posedge i_clk);
        end
        while (expected_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
